/* rtl/core/sbusr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbusr_pkg: shared definitions for the SBUS frame receiver
// Frame layout constants, the emitter state type and the framing-to-unpacker
// control bundle.
// ----------------------------------------------------------------------------
package sbusr_pkg;

	localparam int BYTE_W       = 8;
	localparam int FRAME_LENGTH = 25;
	localparam int NUM_CHANNELS = 16;
	localparam int CHAN_BITS    = 11;
	localparam int DATA_BYTES   = 22;
	localparam int STREAM_BITS  = NUM_CHANNELS * CHAN_BITS;
	localparam int POS_W        = 5;
	localparam int BIT_CNT_W    = 4;
	localparam int CHAN_IDX_W   = 4;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h0F;

	// frame byte positions (start byte is position 0)
	localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
	localparam logic [POS_W-1:0] POS_FIRST     = 5'd1;
	localparam logic [POS_W-1:0] POS_LAST_DATA = POS_W'(DATA_BYTES);
	localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(DATA_BYTES + 1);
	localparam logic [POS_W-1:0] POS_FOOTER    = POS_W'(FRAME_LENGTH - 1);

	// flags byte bits
	localparam int FLAG_LOST_BIT     = 2;
	localparam int FLAG_FAILSAFE_BIT = 3;

	localparam logic [BIT_CNT_W-1:0]  LAST_BIT  = BIT_CNT_W'(CHAN_BITS - 1);
	localparam logic [CHAN_IDX_W-1:0] LAST_CHAN = CHAN_IDX_W'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_SHIFT,
		EMIT_WAIT
	} emit_state_t;

	typedef struct packed {
		logic shift_byte;  // channel data byte accepted
		logic load_flags;  // flags byte accepted
		logic start;       // footer accepted, unpack the frame
	} frame_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/sbusr_byte_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbusr_byte_if: received byte channel
// Valid/ready channel carrying one serial byte per beat.
// ----------------------------------------------------------------------------
interface sbusr_byte_if;
	import sbusr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* rtl/core/sbusr_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbusr_chan_if: channel result channel
// Valid/ready channel carrying one decoded channel per beat.
// ----------------------------------------------------------------------------
interface sbusr_chan_if;
	import sbusr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CHAN_IDX_W-1:0] channel_index;
	logic [CHAN_BITS-1:0]  channel_value;
	logic                  lost_flag;
	logic                  failsafe;
	logic                  last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output lost_flag, output failsafe, output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input lost_flag, input failsafe, input last_channel, output ready);
endinterface
`default_nettype wire

/* rtl/core/sbusr_unpacker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbusr_unpacker: channel data shift register and bit-serial emitter
// Collects the 22 data bytes into a shift line, then peels off one bit per
// cycle to build each 11-bit channel and hands it to the output register.
// ----------------------------------------------------------------------------
module sbusr_unpacker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  sbusr_pkg::frame_ctl_t           ctl,
	input  wire [sbusr_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            busy,
	sbusr_chan_if.source                    chan
);
	import sbusr_pkg::*;

	emit_state_t            state_q, state_d;
	logic [STREAM_BITS-1:0] data_q;
	logic [CHAN_BITS-1:0]   acc_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [CHAN_IDX_W-1:0]  chan_q;
	logic                   lost_q, fs_q;
	logic                   out_valid_q;
	logic                   shift_en, load_out, slot_free;

	assign slot_free = !out_valid_q || chan.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			EMIT_IDLE: begin
				if (ctl.start) state_d = EMIT_SHIFT;
			end
			EMIT_SHIFT: begin
				if (bit_cnt_q == LAST_BIT) state_d = EMIT_WAIT;
			end
			EMIT_WAIT: begin
				if (slot_free) state_d = (chan_q == LAST_CHAN) ? EMIT_IDLE : EMIT_SHIFT;
			end
			default: state_d = EMIT_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		shift_en = 1'b0;
		load_out = 1'b0;
		busy     = 1'b1;
		case (state_q)
			EMIT_IDLE:  busy = 1'b0;
			EMIT_SHIFT: shift_en = 1'b1;
			EMIT_WAIT:  load_out = slot_free;
			default:    busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EMIT_IDLE;
			bit_cnt_q   <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.start) chan_q <= '0;
			else if (load_out) chan_q <= chan_q + 1'b1;
			if (shift_en) bit_cnt_q <= (bit_cnt_q == LAST_BIT) ? '0 : bit_cnt_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (chan.ready) out_valid_q <= 1'b0;
		end
	end

	// payload: data line, channel accumulator, flags, output register
	always_ff @(posedge clk) begin
		if (ctl.shift_byte) data_q <= {rx_byte, data_q[STREAM_BITS-1:BYTE_W]};
		else if (shift_en) data_q <= {1'b0, data_q[STREAM_BITS-1:1]};
		if (shift_en) acc_q <= {data_q[0], acc_q[CHAN_BITS-1:1]};
		if (ctl.load_flags) begin
			lost_q <= rx_byte[FLAG_LOST_BIT];
			fs_q   <= rx_byte[FLAG_FAILSAFE_BIT];
		end
		if (load_out) begin
			chan.channel_index <= chan_q;
			chan.channel_value <= acc_q;
			chan.lost_flag     <= lost_q;
			chan.failsafe      <= fs_q;
			chan.last_channel  <= (chan_q == LAST_CHAN);
		end
	end

	assign chan.valid = out_valid_q;

	// emitter only leaves idle on a footer beat
	a_start_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != EMIT_IDLE && $past(state_q) == EMIT_IDLE) |-> $past(ctl.start))
		else $error("emitter left idle without a frame");

	// no byte may land in the data line while channels are being peeled off
	a_no_shift_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.shift_byte || ctl.start) |-> state_q == EMIT_IDLE)
		else $error("byte taken while emitter busy");

	// returning to idle means channel 15 was just loaded
	a_last_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EMIT_IDLE && $past(state_q) == EMIT_WAIT)
		|-> (chan.valid && chan.last_channel))
		else $error("frame run ended without last channel");

endmodule
`default_nettype wire

/* rtl/core/sbus_frame_receiver_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit: SBUS 16-channel frame decoder
// Hunts for the 0x0F start byte, gathers a 25-byte frame and emits the 16
// proportional channels with the frame-lost and failsafe flags.
// ----------------------------------------------------------------------------
// Feed received bytes on rx, one per beat; results come out on chan, one beat
// per channel in index order 0 to 15, last_channel marking channel 15. While
// hunting every byte other than 0x0F is dropped; a 0x0F inside a frame is just
// data. The footer byte (its value is ignored) starts the unpack: the 176
// data bits are shifted out one per cycle while a channel is being built, and
// each finished 11-bit channel is then loaded into the output register, later
// if the sink stalls. rx.ready is low for that whole unpack; the next frame
// can start while the last channel still waits in the output register. All
// 16 results of a frame carry that frame's flags byte bits 2 and 3.
module sbus_frame_receiver_unit (
	input  wire          clk,
	input  wire          arst_n,
	sbusr_byte_if.sink   rx,
	sbusr_chan_if.source chan
);
	import sbusr_pkg::*;

	logic [POS_W-1:0] pos_q;     // frame bytes taken so far, 0 = hunting
	logic             accept;
	logic             busy;
	frame_ctl_t       ctl;

	assign rx.ready = !busy;
	assign accept   = rx.valid && rx.ready;

	// decode the byte's role from its frame position
	always_comb begin
		ctl.shift_byte = accept && (pos_q >= POS_FIRST) && (pos_q <= POS_LAST_DATA);
		ctl.load_flags = accept && (pos_q == POS_FLAGS);
		ctl.start      = accept && (pos_q == POS_FOOTER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
		end else if (accept) begin
			if (pos_q == POS_HUNT) begin
				if (rx.rx_byte == START_BYTE) pos_q <= POS_FIRST;
			end else if (pos_q >= POS_FOOTER) begin
				// footer taken (or stray position): back to hunting
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	sbusr_unpacker u_unpack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rx_byte (rx.rx_byte),
		.busy    (busy),
		.chan    (chan)
	);

	// position never runs past the footer slot
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_FOOTER)
		else $error("frame position out of range");

	// a footer beat always hands the frame to the unpacker and rewinds
	a_footer_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (pos_q == POS_HUNT && busy))
		else $error("footer did not start unpack");

	// hunting drops non-start bytes
	a_hunt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == POS_HUNT && rx.rx_byte != START_BYTE) |=> pos_q == POS_HUNT)
		else $error("left hunting on non-start byte");

endmodule
`default_nettype wire

/* tb/tb_sbus_frame_receiver_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_receiver_unit: self-checking bench for the SBUS frame decoder
// Streams received bytes into the decoder: dropped noise, directed frames and
// random frames, some of them broken. A scoreboard mirrors the framing and
// unpacking and checks every decoded channel beat field by field in order.
// ----------------------------------------------------------------------------
module tb_sbus_frame_receiver_unit;
	import sbusr_pkg::*;

	localparam int STORE_DEPTH  = FRAME_LENGTH - 1;
	localparam int FLAGS_SLOT   = DATA_BYTES;      // store entry of the flags byte
	localparam int SETTLE_CYCLES = 300;            // one full unpack plus margin
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_BYTES  = 45;

	// one decoded channel as the decoder should present it
	typedef struct {
		logic [CHAN_IDX_W-1:0] index;
		logic [CHAN_BITS-1:0]  value;
		logic                  lost;
		logic                  fsafe;
		logic                  last;
	} chan_beat_t;

	// Mirrors the byte framing and the channel unpack, keeps the decoded
	// channels still owed by the decoder, and compares each one that comes out.
	class channel_scoreboard;
		logic [POS_W-1:0]  frame_pos;
		logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
		chan_beat_t        owed_channels [$];
		int                errors;
		int                frames_done;
		int                channels_checked;

		function new();
			frame_pos = POS_HUNT;
			foreach (frame_bytes[i])
				frame_bytes[i] = '0;
			errors = 0;
			frames_done = 0;
			channels_checked = 0;
		endfunction

		function int pending();
			return owed_channels.size();
		endfunction

		// an rx beat was accepted
		function void take_byte(logic [BYTE_W-1:0] b);
			logic [STREAM_BITS-1:0] bit_stream;
			logic [BYTE_W-1:0]      flags;
			chan_beat_t             beat;
			if (frame_pos == POS_HUNT) begin
				if (b == START_BYTE)
					frame_pos = POS_FIRST;
				return;
			end
			if (frame_pos >= FRAME_LENGTH) begin
				frame_pos = POS_HUNT;
				return;
			end
			frame_bytes[frame_pos - 1] = b;
			frame_pos = frame_pos + 1'b1;
			if (frame_pos < FRAME_LENGTH)
				return;

			frame_pos = POS_HUNT;
			frames_done++;
			flags = frame_bytes[FLAGS_SLOT];
			for (int i = 0; i < DATA_BYTES; i++)
				bit_stream[i*BYTE_W +: BYTE_W] = frame_bytes[i];
			for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
				beat.index = CHAN_IDX_W'(ch);
				beat.value = bit_stream[ch*CHAN_BITS +: CHAN_BITS];
				beat.lost  = flags[FLAG_LOST_BIT];
				beat.fsafe = flags[FLAG_FAILSAFE_BIT];
				beat.last  = (beat.index == LAST_CHAN);
				owed_channels.push_back(beat);
			end
		endfunction

		// a chan beat was accepted
		function void check_channel(logic [CHAN_IDX_W-1:0] index, logic [CHAN_BITS-1:0] value,
				logic lost, logic fsafe, logic last);
			chan_beat_t want;
			if (owed_channels.size() == 0) begin
				$display("%0t: unexpected channel beat index=%0d value=%0d lost=%0b fs=%0b last=%0b",
					$time, index, value, lost, fsafe, last);
				errors++;
				return;
			end
			want = owed_channels.pop_front();
			channels_checked++;
			if (index !== want.index) begin
				$display("%0t: channel_index expected %0d actual %0d", $time, want.index, index);
				errors++;
			end
			if (value !== want.value) begin
				$display("%0t: channel_value (ch %0d) expected %0d actual %0d",
					$time, want.index, want.value, value);
				errors++;
			end
			if (lost !== want.lost) begin
				$display("%0t: lost flag (ch %0d) expected %0b actual %0b",
					$time, want.index, want.lost, lost);
				errors++;
			end
			if (fsafe !== want.fsafe) begin
				$display("%0t: failsafe (ch %0d) expected %0b actual %0b",
					$time, want.index, want.fsafe, fsafe);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_channel (ch %0d) expected %0b actual %0b",
					$time, want.index, want.last, last);
				errors++;
			end
		endfunction

		// anything still owed at the end is a failure
		function void close_out();
			if (owed_channels.size() != 0) begin
				$display("%0t: %0d channel beats never arrived", $time, owed_channels.size());
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sbusr_byte_if rx_if ();
	sbusr_chan_if chan_if ();

	sbus_frame_receiver_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.chan   (chan_if)
	);

	channel_scoreboard sb = new();

	int src_gap_pct;   // chance per cycle that the byte source holds off
	int snk_stall_pct; // chance per cycle that the channel sink stalls
	int bytes_sent;
	int broken_frames;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d channel beats still owed",
				$time, cycle_count, sb.pending());
			$display("[sbus_frame_receiver_unit] ERROR");
			$finish;
		end
	end

	// sink side: random back-pressure, updated on the falling edge
	initial begin
		chan_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			chan_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// result monitor, sampled on the rising edge
	always @(posedge clk)
		if (arst_n && chan_if.valid && chan_if.ready)
			sb.check_channel(chan_if.channel_index, chan_if.channel_value,
				chan_if.lost_flag, chan_if.failsafe, chan_if.last_channel);

	// Offer one byte. Entered and left at a falling edge; valid stays high on
	// exit so back-to-back beats never see a low/high pair in one step.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
		sb.take_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// whole frame with every data byte the same
	task automatic send_fill_frame(input logic [BYTE_W-1:0] fill, input logic [BYTE_W-1:0] flags,
			input logic [BYTE_W-1:0] footer);
		send_byte(START_BYTE);
		repeat (DATA_BYTES)
			send_byte(fill);
		send_byte(flags);
		send_byte(footer);
	endtask

	// Mostly clean frames with random content behind a little noise; now and
	// then a start byte followed by a stray run that shifts the framing.
	task automatic send_random_frame();
		logic [BYTE_W-1:0] noise;
		int                noise_len;
		int                run_len;
		noise_len = $urandom_range(0, 3);
		repeat (noise_len) begin
			noise = BYTE_W'($urandom);
			if (noise == START_BYTE)
				noise = ~noise;
			send_byte(noise);
		end
		if ($urandom_range(0, 5) == 0) begin
			broken_frames++;
			run_len = $urandom_range(1, 30);
			send_byte(START_BYTE);
			repeat (run_len)
				send_byte(BYTE_W'($urandom));
		end else begin
			send_byte(START_BYTE);
			repeat (DATA_BYTES + 2)
				send_byte(BYTE_W'($urandom));
		end
	endtask

	// hold the source off until every owed channel is out, then let the
	// decoder finish any unpack that has nothing left to deliver
	task automatic drain_channels();
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic run_phase(input int gap_pct, input int stall_pct);
		int start_count;
		src_gap_pct   = gap_pct;
		snk_stall_pct = stall_pct;
		start_count   = bytes_sent;
		while (bytes_sent - start_count < PHASE_BYTES)
			send_random_frame();
		drain_channels();
	endtask

	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		bytes_sent    = 0;
		broken_frames = 0;
		src_gap_pct   = 8;
		snk_stall_pct = 68;
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: noise while hunting, then all-ones data with both flags,
		// then start bytes used as data with only frame-lost set
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hF0);
		send_byte(8'h0E);
		send_fill_frame(8'hFF, 8'h0C, 8'h00);
		send_fill_frame(START_BYTE, 8'h04, 8'hFF);
		drain_channels();

		// random: source mostly busy / sink stalling, the reverse, then flat out
		run_phase(8, 68);
		run_phase(68, 8);
		run_phase(0, 0);

		sb.close_out();
		$display("Sent %0d bytes (%0d broken runs); decoded %0d frames, checked %0d channel beats.",
			bytes_sent, broken_frames, sb.frames_done, sb.channels_checked);
		$display("Phases: sink stalling, source gapping, and no back-pressure at all.");
		if (sb.errors == 0)
			$display("[sbus_frame_receiver_unit] OK");
		else
			$display("[sbus_frame_receiver_unit] ERROR");
		$finish;
	end

endmodule
